@@ rtl/channel_duty_cycle_limiter_macros.svh @@
// Assertion macros for the duty-cycle limiter modules.
`ifndef CHANNEL_DUTY_CYCLE_LIMITER_MACROS_SVH
`define CHANNEL_DUTY_CYCLE_LIMITER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define CDCL_ASSERT_NOW(label, clk, rst_n, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
		else $error("cdcl assertion failed: same-cycle implication");

// Next-cycle implication, checked out of reset.
`define CDCL_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
		else $error("cdcl assertion failed: next-cycle implication");

`endif

@@ rtl/cdcl_pkg.sv @@
// Types and constants shared by the duty-cycle limiter modules.
package cdcl_pkg;

	localparam int unsigned CHANNEL_COUNT_DEF = 64;

	localparam int unsigned TIME_W = 32;
	localparam int unsigned CHAN_W = 8;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned CFG_INDEX_W = 8;

	localparam logic [TIME_W-1:0] WINDOW_LENGTH_RESET = 32'd100000;
	localparam logic [TIME_W-1:0] BUDGET_RESET = 32'd10000;

	localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LENGTH = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_BUDGET = 8'd1;

	localparam logic [STATUS_W-1:0] STATUS_GRANTED = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_BAD_CHANNEL = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_OVER_BUDGET = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic check;
	} cmd_t;

endpackage

@@ rtl/cdcl_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module cdcl_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/cdcl_ctrl.sv @@
// Controller state machine of the duty-cycle limiter.
`include "channel_duty_cycle_limiter_macros.svh"

module cdcl_ctrl import cdcl_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	output logic done,
	output cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE  = 2'b01,
		ST_CHECK = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   done_q;

	assign busy = (state_q == ST_CHECK);
	assign cmd.accept = start && !busy;
	assign cmd.check = (state_q == ST_CHECK);

	always_comb begin
		case (state_q)
			ST_IDLE:  state_d = cmd.accept ? ST_CHECK : ST_IDLE;
			ST_CHECK: state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q <= cmd.check;
		end
	end

	assign done = done_q;

	`CDCL_ASSERT_NEXT(a_accept_then_check, clk, arst_n, cmd.accept, cmd.check)
	`CDCL_ASSERT_NEXT(a_check_then_done, clk, arst_n, cmd.check, done && !busy)
	`CDCL_ASSERT_NOW(a_done_not_busy, clk, arst_n, done, !cmd.check)

endmodule

@@ rtl/cdcl_dp.sv @@
// Datapath of the duty-cycle limiter: registers, window check and budget check.
module cdcl_dp import cdcl_pkg::*; #(
	parameter int unsigned CHANNEL_COUNT = CHANNEL_COUNT_DEF,
	localparam int unsigned AW = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cmd_t                   cmd,
	input  logic [CHAN_W-1:0]      channel,
	input  logic [TIME_W-1:0]      airtime_ms,
	input  logic [TIME_W-1:0]      now_ms,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [TIME_W-1:0]      cfg_data,
	output logic                   granted,
	output logic [STATUS_W-1:0]    status
);

	localparam logic [CHAN_W:0] CHAN_LIMIT = (CHAN_W+1)'(CHANNEL_COUNT);

	logic [TIME_W-1:0]   win_len_q;
	logic [TIME_W-1:0]   budget_q;
	logic [TIME_W-1:0]   win_start_q;
	logic [CHANNEL_COUNT-1:0] valid_q;

	logic [AW-1:0]       idx_s1;
	logic                bad_s1;
	logic [TIME_W-1:0]   air_s1;

	logic                granted_q;
	logic [STATUS_W-1:0] status_q;

	logic [TIME_W-1:0]   elapsed;
	logic                restart;
	logic [TIME_W-1:0]   rdata;
	logic [TIME_W-1:0]   total;
	logic [TIME_W:0]     sum;
	logic                over;
	logic                we;

	assign elapsed = now_ms - win_start_q;
	assign restart = cmd.accept && (elapsed >= win_len_q);

	// A total whose valid bit is clear was cleared by reset or a window restart.
	assign total = valid_q[idx_s1] ? rdata : '0;
	assign sum = {1'b0, total} + {1'b0, air_s1};
	assign over = sum > {1'b0, budget_q};
	assign we = cmd.check && !bad_s1 && !over;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_len_q <= WINDOW_LENGTH_RESET;
			budget_q <= BUDGET_RESET;
			win_start_q <= '0;
			valid_q <= '0;
		end else begin
			if (cfg_we && cfg_index == REG_WINDOW_LENGTH) begin
				win_len_q <= cfg_data;
			end
			if (cfg_we && cfg_index == REG_BUDGET) begin
				budget_q <= cfg_data;
			end
			if (restart) begin
				win_start_q <= now_ms;
				valid_q <= '0;
			end else if (we) begin
				valid_q[idx_s1] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			idx_s1 <= channel[AW-1:0];
			bad_s1 <= {1'b0, channel} >= CHAN_LIMIT;
			air_s1 <= airtime_ms;
		end
		if (cmd.check) begin
			if (bad_s1) begin
				granted_q <= 1'b0;
				status_q <= STATUS_BAD_CHANNEL;
			end else if (over) begin
				granted_q <= 1'b0;
				status_q <= STATUS_OVER_BUDGET;
			end else begin
				granted_q <= 1'b1;
				status_q <= STATUS_GRANTED;
			end
		end
	end

	cdcl_ram #(
		.WIDTH(TIME_W),
		.DEPTH(CHANNEL_COUNT)
	) u_totals (
		.clk  (clk),
		.we   (we),
		.waddr(idx_s1),
		.wdata(sum[TIME_W-1:0]),
		.raddr(channel[AW-1:0]),
		.rdata(rdata)
	);

	assign granted = granted_q;
	assign status = status_q;

endmodule

@@ rtl/channel_duty_cycle_limiter.sv @@
// Top level of the per-channel duty-cycle limiter with a fixed accounting window.
// A taken request is checked in the CHECK state; the registered result comes with done.
// No new request is taken while busy, during the read-modify-write of the totals RAM.
// Reset (arst_n low, asynchronous) restores window length 100000 ms, budget 10000 ms,
// window start zero and marks every channel total as zero at once; no clearing pass.
module channel_duty_cycle_limiter import cdcl_pkg::*; #(
	parameter int unsigned CHANNEL_COUNT = CHANNEL_COUNT_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [CHAN_W-1:0]      channel,
	input  logic [TIME_W-1:0]      airtime_ms,
	input  logic [TIME_W-1:0]      now_ms,
	output logic                   done,
	output logic                   granted,
	output logic [STATUS_W-1:0]    status,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [TIME_W-1:0]      cfg_data
);

	// A request is taken when start is high and busy is low. In that cycle the
	// datapath checks the window against now_ms: if it has run out, the window
	// restarts and every channel's valid bit is cleared, so all totals read as
	// zero. The channel's total is read from the RAM at the same edge.
	//
	// In the following cycle (busy high) the total and the airtime are added
	// without wrap and compared with the budget; a granted request writes the
	// new total back. The result is registered and shown for one cycle with
	// done high; the receiver cannot hold it off, and a new request may be
	// taken in that same cycle.
	cmd_t cmd;

	// Configuration transfers are always accepted; writes to an index beyond
	// the register list are dropped.
	assign cfg_ready = 1'b1;

	cdcl_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.done  (done),
		.cmd   (cmd)
	);

	cdcl_dp #(
		.CHANNEL_COUNT(CHANNEL_COUNT)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.channel   (channel),
		.airtime_ms(airtime_ms),
		.now_ms    (now_ms),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.granted   (granted),
		.status    (status)
	);

endmodule

@@ bench/channel_duty_cycle_limiter_test.sv @@
// Self-checking testbench for the per-channel duty-cycle limiter with a fixed window.
module channel_duty_cycle_limiter_test import cdcl_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	// Register indexes that lie beyond the register list; writes to them must be ignored.
	localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED_LOW = 8'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED_TOP = 8'hFF;

	// One expected result: the grant flag and the status code that goes with it.
	typedef struct packed {
		logic                granted;
		logic [STATUS_W-1:0] status;
	} decision_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   start = 1'b0;
	logic                   busy;
	logic [CHAN_W-1:0]      channel = '0;
	logic [TIME_W-1:0]      airtime_ms = '0;
	logic [TIME_W-1:0]      now_ms = '0;
	logic                   done;
	logic                   granted;
	logic [STATUS_W-1:0]    status;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [TIME_W-1:0]      cfg_data = '0;

	// Our own copy of the limiter's registers and airtime accounting.
	logic [TIME_W-1:0] cfg_window_ms = WINDOW_LENGTH_RESET;
	logic [TIME_W-1:0] cfg_budget_ms = BUDGET_RESET;
	logic [TIME_W-1:0] airtime_used [CHANNEL_COUNT_DEF];
	logic [TIME_W-1:0] window_origin_ms = '0;

	// Decisions still owed by the block, oldest first.
	decision_t pending_decisions[$];

	// Percentage of requests that are preceded by a gap on the request side.
	int idle_pct = 0;

	// Running millisecond clock for the random traffic.
	logic [TIME_W-1:0] clock_ms = '0;

	int fail_count = 0;
	int sent_count = 0;
	int grant_count = 0;
	int bad_channel_count = 0;
	int over_budget_count = 0;

	channel_duty_cycle_limiter u_dut (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	// Works out what the limiter must answer to a request, and updates our copy of its
	// accounting exactly as the block should. The window is checked first, using a
	// wrapping 32-bit difference, so even a request on an invalid channel may restart it.
	function automatic decision_t decide_request(input logic [CHAN_W-1:0] req_channel,
			input logic [TIME_W-1:0] req_airtime, input logic [TIME_W-1:0] req_now);
		decision_t         d;
		logic [TIME_W-1:0] elapsed;
		logic [TIME_W:0]   new_total;
		elapsed = req_now - window_origin_ms;
		if (elapsed >= cfg_window_ms) begin
			foreach (airtime_used[i])
				airtime_used[i] = '0;
			window_origin_ms = req_now;
		end
		if (req_channel >= CHANNEL_COUNT_DEF) begin
			d.granted = 1'b0;
			d.status = STATUS_BAD_CHANNEL;
			return d;
		end
		// The sum is formed one bit wider so that it can never wrap.
		new_total = {1'b0, airtime_used[req_channel]} + {1'b0, req_airtime};
		if (new_total > {1'b0, cfg_budget_ms}) begin
			d.granted = 1'b0;
			d.status = STATUS_OVER_BUDGET;
			return d;
		end
		airtime_used[req_channel] = new_total[TIME_W-1:0];
		d.granted = 1'b1;
		d.status = STATUS_GRANTED;
		return d;
	endfunction

	// Sends one request and records what it must produce. The request is raised at a
	// clock edge and held until an edge at which busy is low, which is the transfer.
	// Before the request the sender may first sit idle, driving junk on the
	// request fields meanwhile so that the block is seen to ignore them without start.
	// After the transfer start is deliberately left high, so that back-to-back requests
	// never lower and raise it within the same time step.
	task automatic issue_request(input logic [CHAN_W-1:0] req_channel,
			input logic [TIME_W-1:0] req_airtime, input logic [TIME_W-1:0] req_now);
		int        gap;
		decision_t d;
		if ($urandom_range(0, 99) < idle_pct) begin
			gap = $urandom_range(1, 6);
			start <= 1'b0;
			repeat (gap) begin
				channel <= CHAN_W'($urandom);
				airtime_ms <= $urandom;
				now_ms <= $urandom;
				@(posedge clk);
			end
		end
		start <= 1'b1;
		channel <= req_channel;
		airtime_ms <= req_airtime;
		now_ms <= req_now;
		do
			@(posedge clk);
		while (busy);
		d = decide_request(req_channel, req_airtime, req_now);
		pending_decisions.push_back(d);
		sent_count++;
		case (d.status)
			STATUS_GRANTED:     grant_count++;
			STATUS_BAD_CHANNEL: bad_channel_count++;
			default:            over_budget_count++;
		endcase
	endtask

	// Writes one register. This is only done with the block idle: start is dropped,
	// every owed decision must have arrived, and the block is then left to settle.
	task automatic write_register(input logic [CFG_INDEX_W-1:0] reg_index,
			input logic [TIME_W-1:0] reg_value);
		start <= 1'b0;
		while (pending_decisions.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= reg_index;
		cfg_data <= reg_value;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (reg_index == REG_WINDOW_LENGTH)
			cfg_window_ms = reg_value;
		else if (reg_index == REG_BUDGET)
			cfg_budget_ms = reg_value;
	endtask

	// Out of reset: window 100000 ms and budget 10000 ms. A channel may use its whole
	// budget, a zero airtime is still granted at the full total, one more millisecond
	// is refused, and channels at or above the channel count are rejected outright.
	task automatic test_reset_defaults();
		issue_request(8'd0, 32'd10000, 32'd5);
		issue_request(8'd0, 32'd0, 32'd6);
		issue_request(8'd0, 32'd1, 32'd7);
		issue_request(8'd63, 32'd10001, 32'd8);
		issue_request(8'd64, 32'd1, 32'd9);
		issue_request(8'd255, 32'd0, 32'd10);
		// Exactly one window length after the start, so the totals are cleared first.
		issue_request(8'd0, 32'd5000, 32'd100000);
	endtask

	// Window edges with a short window, including a time value that wraps past zero
	// and a restart caused by a request on an invalid channel.
	task automatic test_window_edges();
		logic [TIME_W-1:0] t0;
		t0 = 32'hFFFF_FF00;
		write_register(REG_WINDOW_LENGTH, 32'd1000);
		write_register(REG_BUDGET, 32'd100);
		issue_request(8'd2, 32'd60, t0);
		issue_request(8'd2, 32'd40, t0 + 32'd999);
		issue_request(8'd2, 32'd1, t0 + 32'd999);
		issue_request(8'd2, 32'd1, t0 + 32'd1000);
		issue_request(8'd200, 32'd7, t0 + 32'd5000);
		issue_request(8'd2, 32'd100, t0 + 32'd5000);
	endtask

	// A zero window length clears every total on every request, and a zero budget
	// allows only zero airtime.
	task automatic test_zero_window();
		write_register(REG_WINDOW_LENGTH, 32'd0);
		write_register(REG_BUDGET, 32'd0);
		issue_request(8'd3, 32'd0, 32'd42);
		issue_request(8'd3, 32'd1, 32'd42);
		write_register(REG_BUDGET, 32'd50);
		issue_request(8'd3, 32'd50, 32'd42);
		issue_request(8'd3, 32'd50, 32'd42);
	endtask

	// Largest window and budget: a total at the top of the range plus one must be
	// refused rather than wrap. Writes to indexes beyond the register list change
	// nothing; the last two requests show that the budget is kept.
	task automatic test_budget_extremes();
		write_register(REG_WINDOW_LENGTH, 32'hFFFF_FFFF);
		write_register(REG_BUDGET, 32'hFFFF_FFFF);
		issue_request(8'd4, 32'hFFFF_FFFF, 32'd1000);
		issue_request(8'd4, 32'd1, 32'd1001);
		issue_request(8'd4, 32'd0, 32'd1002);
		write_register(REG_UNMAPPED_LOW, 32'd0);
		write_register(REG_UNMAPPED_TOP, 32'd0);
		issue_request(8'd5, 32'hFFFF_FFFE, 32'd1003);
		issue_request(8'd5, 32'd1, 32'd1004);
	endtask

	// Random traffic in four chunks, each under freshly chosen settings. Requests
	// crowd onto a few channels so that budgets run out, time mostly creeps forward
	// so that totals build up, and now and then leaps a window or jumps anywhere.
	task automatic test_random_traffic(input int gap_pct, input int item_count);
		logic [CHAN_W-1:0] req_channel;
		logic [TIME_W-1:0] req_airtime;
		logic [TIME_W-1:0] new_window;
		logic [TIME_W-1:0] new_budget;
		idle_pct = gap_pct;
		repeat (4) begin
			case ($urandom_range(0, 5))
				0:       new_window = 32'd0;
				1:       new_window = 32'd1;
				2:       new_window = $urandom_range(10, 3000);
				3:       new_window = WINDOW_LENGTH_RESET;
				4:       new_window = 32'hFFFF_FFFF;
				default: new_window = $urandom;
			endcase
			case ($urandom_range(0, 4))
				0:       new_budget = 32'd0;
				1:       new_budget = $urandom_range(1, 500);
				2:       new_budget = $urandom_range(500, 20000);
				3:       new_budget = 32'hFFFF_FFFF;
				default: new_budget = $urandom;
			endcase
			write_register(REG_WINDOW_LENGTH, new_window);
			write_register(REG_BUDGET, new_budget);
			repeat (item_count / 4) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4, 5, 6: req_channel = CHAN_W'($urandom_range(0, 7));
					7, 8:                req_channel = CHAN_W'($urandom_range(0,
								CHANNEL_COUNT_DEF - 1));
					default:             req_channel = CHAN_W'($urandom_range(
								CHANNEL_COUNT_DEF, 255));
				endcase
				case ($urandom_range(0, 9))
					0:       req_airtime = 32'd0;
					1:       req_airtime = $urandom;
					2:       req_airtime = 32'hFFFF_FFFF;
					default: req_airtime = $urandom_range(0, cfg_budget_ms / 8 + 16);
				endcase
				case ($urandom_range(0, 9))
					7:       clock_ms += $urandom_range(0, cfg_window_ms);
					8:       clock_ms = $urandom;
					9:       ;
					default: clock_ms += $urandom_range(0, 50);
				endcase
				issue_request(req_channel, req_airtime, clock_ms);
			end
		end
	endtask

	// Results are taken at the falling edge while done is high, so the expectation
	// pushed at the request's own transfer is always in place first.
	always @(negedge clk) begin
		if (arst_n && done) begin
			if (pending_decisions.size() == 0) begin
				$display("%0t: result with none expected: granted %0b status %0d",
					$time, granted, status);
				fail_count++;
			end else begin
				if (granted !== pending_decisions[0].granted) begin
					$display("%0t: granted mismatch: expected %0b, got %0b",
						$time, pending_decisions[0].granted, granted);
					fail_count++;
				end
				if (status !== pending_decisions[0].status) begin
					$display("%0t: status mismatch: expected %0d, got %0d",
						$time, pending_decisions[0].status, status);
					fail_count++;
				end
				pending_decisions.delete(0);
			end
		end
	end

	// Safety net: a hung handshake must not leave the run waiting for ever.
	initial begin
		#2000000;
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		foreach (airtime_used[i])
			airtime_used[i] = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_window_edges();
		test_zero_window();
		test_budget_extremes();
		test_random_traffic(0, 360);
		test_random_traffic(72, 360);
		test_random_traffic(24, 360);

		// Drain: wait until every owed decision has arrived.
		start <= 1'b0;
		for (int i = 0; i < 200 && pending_decisions.size() != 0; i++)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (pending_decisions.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time,
				pending_decisions.size());
			fail_count++;
		end

		$display("Sent %0d requests under directed and random settings, with and without gaps.",
			sent_count);
		$display("Decisions seen: %0d granted, %0d invalid channel, %0d over budget.",
			grant_count, bad_channel_count, over_budget_count);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+rtl
rtl/cdcl_pkg.sv
rtl/cdcl_ram.sv
rtl/cdcl_ctrl.sv
rtl/cdcl_dp.sv
rtl/channel_duty_cycle_limiter.sv
bench/channel_duty_cycle_limiter_test.sv
